@@ hw/rtl/square_tone_generator_with_fade_core_macros.svh @@
// assertion macros used by the checker file
`ifndef SQUARE_TONE_GENERATOR_WITH_FADE_CORE_MACROS_SVH
`define SQUARE_TONE_GENERATOR_WITH_FADE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define STG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define STG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/stg_pkg.sv @@
package stg_pkg;

	localparam int PHASE_BITS   = 32;
	localparam int SAMPLE_SHIFT = 12;

	localparam int RATE_W   = 18;
	localparam int FIELD_W  = 16;
	localparam int SAMPLE_W = 28;
	localparam int COUNT_W  = 24;
	localparam int FADE_W   = 10;
	localparam int PEAK_W   = 15;
	localparam int PROD_W   = RATE_W + FIELD_W;
	localparam int SCALE_W  = PEAK_W + FADE_W;
	localparam int DIV_W    = (PHASE_BITS + FIELD_W > PROD_W) ? PHASE_BITS + FIELD_W : PROD_W;
	localparam int DVS_W    = RATE_W;
	localparam int CNT_W    = $clog2(DIV_W + 1);
	localparam int CFG_IDX_W = 1;

	// fixed divisions by reciprocal multiplication
	// n/1000 taken as (n/8)/125, exact for a product below 2^34
	// rate/200 exact for an 18-bit rate
	localparam int TOTAL_PRE_SHIFT = 3;
	localparam int RCP_A_W = PROD_W - TOTAL_PRE_SHIFT;
	localparam int RCP_B_W = 32;
	localparam int RCP_P_W = RCP_A_W + RCP_B_W;
	localparam logic [RCP_B_W-1:0] RCP_125 = 32'd2199023256;
	localparam int RCP_125_SHIFT = 38;
	localparam logic [RCP_B_W-1:0] RCP_200 = 32'd335545;
	localparam int RCP_200_SHIFT = 26;

	localparam logic [RATE_W-1:0]  RATE_RESET    = RATE_W'(16000);
	localparam logic [DVS_W-1:0]   TOTAL_DIVISOR = DVS_W'(1000);
	localparam logic [DVS_W-1:0]   FADE_DIVISOR  = DVS_W'(200);
	localparam logic [FIELD_W-1:0] PEAK_MAX      = FIELD_W'(32767);
	localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
	localparam logic [FADE_W-1:0]  FADE_MAX      = {FADE_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_RATE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(1);

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_ARG = 2'd1,
		ST_IDLE    = 2'd2
	} status_t;

	typedef struct packed {
		logic               mode;
		logic [FIELD_W-1:0] freq_hz;
		logic [FIELD_W-1:0] dur_ms;
		logic [FIELD_W-1:0] amplitude;
	} item_t;

	typedef struct packed {
		status_t                    status;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} result_t;

	typedef enum logic [3:0] {
		A_NONE,
		A_LD_TOTAL,
		A_DIV,
		A_SET_TOTAL,
		A_LD_FADE,
		A_SET_FADE,
		A_LD_PHASE,
		A_START_OK,
		A_REJECT,
		A_LD_MAG,
		A_LD_FIN,
		A_SET_MAG,
		A_LD_FOUT,
		A_EMIT_TICK,
		A_EMIT_IDLE,
		A_RECIP
	} action_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_IS_TICK,
		C_BAD_ARGS,
		C_DIV_MORE,
		C_NO_TONE,
		C_NO_FADE_IN,
		C_NO_FADE_OUT
	} cond_t;

	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t P_DISPATCH  = 5'd0;
	localparam step_t P_CHECK     = 5'd1;
	localparam step_t P_LD_TOTAL  = 5'd2;
	localparam step_t P_DIV_TOTAL = 5'd3;
	localparam step_t P_SET_TOTAL = 5'd4;
	localparam step_t P_LD_FADE   = 5'd5;
	localparam step_t P_DIV_FADE  = 5'd6;
	localparam step_t P_SET_FADE  = 5'd7;
	localparam step_t P_LD_PHASE  = 5'd8;
	localparam step_t P_DIV_PHASE = 5'd9;
	localparam step_t P_START_OK  = 5'd10;
	localparam step_t P_REJECT    = 5'd11;
	localparam step_t P_TICK      = 5'd12;
	localparam step_t P_LD_FIN    = 5'd13;
	localparam step_t P_DIV_FIN   = 5'd14;
	localparam step_t P_SET_FIN   = 5'd15;
	localparam step_t P_LD_FOUT   = 5'd16;
	localparam step_t P_DIV_FOUT  = 5'd17;
	localparam step_t P_SET_FOUT  = 5'd18;
	localparam step_t P_EMIT_TICK = 5'd19;
	localparam step_t P_IDLE      = 5'd20;

	typedef struct packed {
		action_t act;
		cond_t   cond;
		step_t   target;
		logic    done;
	} ctrl_t;

	// control store: one word per step
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		w = '{act: A_NONE, cond: C_NEXT, target: P_DISPATCH, done: 1'b0};
		unique case (step)
			P_DISPATCH:  w = '{A_NONE,      C_IS_TICK,     P_TICK,      1'b0};
			P_CHECK:     w = '{A_NONE,      C_BAD_ARGS,    P_REJECT,    1'b0};
			P_LD_TOTAL:  w = '{A_LD_TOTAL,  C_NEXT,        P_DISPATCH,  1'b0};
			P_DIV_TOTAL: w = '{A_RECIP,     C_NEXT,        P_DISPATCH,  1'b0};
			P_SET_TOTAL: w = '{A_SET_TOTAL, C_NEXT,        P_DISPATCH,  1'b0};
			P_LD_FADE:   w = '{A_LD_FADE,   C_NEXT,        P_DISPATCH,  1'b0};
			P_DIV_FADE:  w = '{A_RECIP,     C_NEXT,        P_DISPATCH,  1'b0};
			P_SET_FADE:  w = '{A_SET_FADE,  C_NEXT,        P_DISPATCH,  1'b0};
			P_LD_PHASE:  w = '{A_LD_PHASE,  C_NEXT,        P_DISPATCH,  1'b0};
			P_DIV_PHASE: w = '{A_DIV,       C_DIV_MORE,    P_DIV_PHASE, 1'b0};
			P_START_OK:  w = '{A_START_OK,  C_NEXT,        P_DISPATCH,  1'b1};
			P_REJECT:    w = '{A_REJECT,    C_NEXT,        P_DISPATCH,  1'b1};
			P_TICK:      w = '{A_LD_MAG,    C_NO_TONE,     P_IDLE,      1'b0};
			P_LD_FIN:    w = '{A_LD_FIN,    C_NO_FADE_IN,  P_LD_FOUT,   1'b0};
			P_DIV_FIN:   w = '{A_DIV,       C_DIV_MORE,    P_DIV_FIN,   1'b0};
			P_SET_FIN:   w = '{A_SET_MAG,   C_NEXT,        P_DISPATCH,  1'b0};
			P_LD_FOUT:   w = '{A_LD_FOUT,   C_NO_FADE_OUT, P_EMIT_TICK, 1'b0};
			P_DIV_FOUT:  w = '{A_DIV,       C_DIV_MORE,    P_DIV_FOUT,  1'b0};
			P_SET_FOUT:  w = '{A_SET_MAG,   C_NEXT,        P_DISPATCH,  1'b0};
			P_EMIT_TICK: w = '{A_EMIT_TICK, C_NEXT,        P_DISPATCH,  1'b1};
			P_IDLE:      w = '{A_EMIT_IDLE, C_NEXT,        P_DISPATCH,  1'b1};
			default:     w = '{A_NONE,      C_NEXT,        P_DISPATCH,  1'b1};
		endcase
		return w;
	endfunction

endpackage

@@ hw/rtl/square_tone_generator_with_fade_core.sv @@
// channel   direction  payload            handshake
// item      in         stg_pkg::item_t    item_valid / item_stall
// result    out        stg_pkg::result_t  result_valid / result_stall
// cfg       in         cfg_index/cfg_data cfg_we, no wait
//
// the phase step and the fade scaling use the shared restoring divider, one quotient bit
// a cycle; the fixed divisions by 1000 and 200 are one reciprocal multiply each
// arst_n clears control, configuration and tone state; the rate register resets to 16000
// item_stall is high while the sequencer runs; a finished result waits in the output
// register, and the final step of the next item holds there while result_stall keeps it full
module square_tone_generator_with_fade_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  stg_pkg::item_t                      item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output stg_pkg::result_t                    result,
	input  logic                                cfg_we,
	input  logic [stg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [stg_pkg::RATE_W-1:0]          cfg_data
);
	import stg_pkg::*;

	// configuration
	logic [RATE_W-1:0] rate_q;
	logic              enable_q;

	// sequencer
	logic  running_q;
	step_t step_q;
	ctrl_t cw;
	logic  slot_free;
	logic  hold;
	logic  fire;
	logic  take_jump;

	// tone state
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] incr_q;
	logic [COUNT_W-1:0]    total_q;
	logic [COUNT_W-1:0]    pos_q;
	logic [FADE_W-1:0]     fade_q;
	logic [PEAK_W-1:0]     peak_q;
	logic                  active_q;

	// datapath working registers
	item_t              item_q;
	logic [DIV_W-1:0]   acc_q;
	logic [DVS_W-1:0]   rem_q;
	logic [DVS_W-1:0]   dvs_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PEAK_W-1:0]  mag_q;
	logic [COUNT_W-1:0] remain_q;
	result_t            result_q;

	// combinational datapath
	logic [RATE_W-1:0]   mul_a;
	logic [FIELD_W-1:0]  mul_b;
	logic [PROD_W-1:0]   prod;
	logic [DVS_W:0]      r_sh;
	logic [DVS_W:0]      r_diff;
	logic                q_bit;
	logic                recip_fade;
	logic [RCP_A_W-1:0]  rcp_a;
	logic [RCP_B_W-1:0]  rcp_b;
	logic [RCP_P_W-1:0]  rcp_prod;
	logic [RCP_A_W-1:0]  rcp_quot;
	logic                bad_args;
	logic                fade_in;
	logic                fade_out;
	logic [SAMPLE_W-1:0] shifted;
	logic [SAMPLE_W-1:0] level;
	logic [COUNT_W-1:0]  pos_next;
	logic                is_last;

	assign cw = ucode(step_q);

	// the output register takes a new result when empty or being emptied
	assign slot_free  = !result_valid || !result_stall;
	assign hold       = cw.done && !slot_free;
	assign fire       = running_q && !hold;
	assign item_stall = running_q;

	assign result = result_q;

	// argument check for a start transaction
	assign bad_args = !enable_q || (rate_q == '0) || (item_q.freq_hz == '0)
		|| (item_q.dur_ms == '0) || (item_q.amplitude == '0)
		|| (item_q.amplitude > PEAK_MAX);

	assign fade_in  = (fade_q != '0) && (pos_q < COUNT_W'(fade_q));
	assign fade_out = (fade_q != '0) && (remain_q < COUNT_W'(fade_q));

	always_comb begin
		unique case (cw.cond)
			C_NEXT:        take_jump = 1'b0;
			C_IS_TICK:     take_jump = (item_q.mode == MODE_TICK);
			C_BAD_ARGS:    take_jump = bad_args;
			C_DIV_MORE:    take_jump = (cnt_q > CNT_W'(1));
			C_NO_TONE:     take_jump = !active_q;
			C_NO_FADE_IN:  take_jump = !fade_in;
			C_NO_FADE_OUT: take_jump = !fade_out;
			default:       take_jump = 1'b0;
		endcase
	end

	// shared product multiplier, apart from the reciprocal one: rate by duration, or level by fade position
	always_comb begin
		unique case (cw.act)
			A_LD_FIN: begin
				mul_a = RATE_W'(mag_q);
				mul_b = FIELD_W'(pos_q[FADE_W-1:0]);
			end
			A_LD_FOUT: begin
				mul_a = RATE_W'(mag_q);
				mul_b = FIELD_W'(remain_q[FADE_W-1:0]);
			end
			default: begin
				mul_a = rate_q;
				mul_b = item_q.dur_ms;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	// restoring divide step: dividend leaves at the top of acc, quotient enters at the bottom
	assign r_sh   = {rem_q, acc_q[DIV_W-1]};
	assign r_diff = r_sh - {1'b0, dvs_q};
	assign q_bit  = !r_diff[DVS_W];

	// fixed divisors: sample count as (product/8)/125, fade length as rate/200
	assign recip_fade = (dvs_q == FADE_DIVISOR);
	assign rcp_a      = recip_fade ? RCP_A_W'(acc_q[RATE_W-1:0])
		: acc_q[PROD_W-1:TOTAL_PRE_SHIFT];
	assign rcp_b      = recip_fade ? RCP_200 : RCP_125;
	assign rcp_prod   = RCP_P_W'(rcp_a) * RCP_P_W'(rcp_b);
	assign rcp_quot   = recip_fade ? RCP_A_W'(rcp_prod >> RCP_200_SHIFT)
		: RCP_A_W'(rcp_prod >> RCP_125_SHIFT);

	// sample level and position update for a tick
	assign shifted  = SAMPLE_W'(mag_q) << SAMPLE_SHIFT;
	assign level    = phase_q[PHASE_BITS-1] ? shifted : (SAMPLE_W'(0) - shifted);
	assign pos_next = pos_q + COUNT_W'(1);
	assign is_last  = (pos_next >= total_q);

	// control, configuration and tone state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q       <= RATE_RESET;
			enable_q     <= 1'b0;
			running_q    <= 1'b0;
			step_q       <= P_DISPATCH;
			result_valid <= 1'b0;
			phase_q      <= '0;
			incr_q       <= '0;
			total_q      <= '0;
			pos_q        <= '0;
			fade_q       <= '0;
			peak_q       <= '0;
			active_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RATE:   rate_q   <= cfg_data;
					REG_ENABLE: enable_q <= cfg_data[0];
					default:    ;
				endcase
			end

			// a result leaving while the next one is finished stays valid
			if (result_valid && !result_stall && !(fire && cw.done)) begin
				result_valid <= 1'b0;
			end

			if (!running_q) begin
				if (item_valid) begin
					running_q <= 1'b1;
					step_q    <= P_DISPATCH;
				end
			end else if (fire) begin
				if (cw.done) begin
					running_q    <= 1'b0;
					result_valid <= 1'b1;
				end
				step_q <= take_jump ? cw.target : step_q + STEP_W'(1);

				unique case (cw.act)
					A_SET_TOTAL: begin
						total_q <= (|acc_q[DIV_W-1:COUNT_W]) ? COUNT_MAX
							: acc_q[COUNT_W-1:0];
					end
					A_SET_FADE: begin
						fade_q <= (|acc_q[DIV_W-1:FADE_W]) ? FADE_MAX : acc_q[FADE_W-1:0];
					end
					A_START_OK: begin
						// new tone replaces any running one
						incr_q   <= acc_q[PHASE_BITS-1:0];
						phase_q  <= '0;
						pos_q    <= '0;
						peak_q   <= item_q.amplitude[PEAK_W-1:0];
						active_q <= (total_q != '0);
					end
					A_EMIT_TICK: begin
						phase_q <= phase_q + incr_q;
						pos_q   <= pos_next;
						if (is_last) begin
							active_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		if (!running_q && item_valid) begin
			item_q <= item;
		end
		if (fire) begin
			unique case (cw.act)
				A_LD_TOTAL: begin
					acc_q <= DIV_W'(prod);
					dvs_q <= TOTAL_DIVISOR;
				end
				A_LD_FADE: begin
					acc_q <= DIV_W'(rate_q);
					dvs_q <= FADE_DIVISOR;
				end
				A_RECIP: begin
					acc_q <= DIV_W'(rcp_quot);
				end
				A_LD_PHASE: begin
					acc_q <= DIV_W'({item_q.freq_hz, {PHASE_BITS{1'b0}}})
						<< (DIV_W - PHASE_BITS - FIELD_W);
					rem_q <= '0;
					dvs_q <= rate_q;
					cnt_q <= CNT_W'(PHASE_BITS + FIELD_W);
				end
				A_LD_FIN, A_LD_FOUT: begin
					acc_q <= DIV_W'(prod[SCALE_W-1:0]) << (DIV_W - SCALE_W);
					rem_q <= '0;
					dvs_q <= DVS_W'(fade_q);
					cnt_q <= CNT_W'(SCALE_W);
				end
				A_DIV: begin
					acc_q <= {acc_q[DIV_W-2:0], q_bit};
					rem_q <= q_bit ? r_diff[DVS_W-1:0] : r_sh[DVS_W-1:0];
					cnt_q <= cnt_q - CNT_W'(1);
				end
				A_LD_MAG: begin
					mag_q    <= peak_q;
					remain_q <= total_q - pos_q;
				end
				A_SET_MAG: begin
					mag_q <= acc_q[PEAK_W-1:0];
				end
				A_START_OK: begin
					result_q <= '{status: ST_OK, sample: '0, last: 1'b0};
				end
				A_REJECT: begin
					result_q <= '{status: ST_BAD_ARG, sample: '0, last: 1'b0};
				end
				A_EMIT_IDLE: begin
					result_q <= '{status: ST_IDLE, sample: '0, last: 1'b0};
				end
				A_EMIT_TICK: begin
					result_q <= '{status: ST_OK, sample: level, last: is_last};
				end
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/stg_checker.sv @@
`include "square_tone_generator_with_fade_core_macros.svh"

module stg_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input stg_pkg::result_t result
);
	import stg_pkg::*;

	// a stalled result holds
	`STG_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result transaction changed")

	// one transaction at a time: the block is busy right after taking one
	`STG_ASSERT_NEXT(a_busy_after_take, clk, arst_n, item_valid && !item_stall, item_stall, "item taken while sequencer not busy")

	// only ok ticks carry a level or the last mark
	`STG_ASSERT_NOW(a_quiet_non_ok, clk, arst_n, result_valid && (result.status != ST_OK), (result.sample == '0) && !result.last, "non-ok result with level or last")

	`STG_ASSERT_NOW(a_status_code, clk, arst_n, result_valid, (result.status == ST_OK) || (result.status == ST_BAD_ARG) || (result.status == ST_IDLE), "undefined status code")

endmodule

bind square_tone_generator_with_fade_core stg_checker u_stg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import stg_pkg::*;

	// overall cycle budget before the run is declared hung
	localparam int CYCLE_LIMIT = 3000000;
	// random transactions queued per configuration phase
	localparam int PHASE_ITEMS = 155;
	// cycles to wait after the last result, longer than an accepted start
	localparam int DRAIN_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// item channel, driven at the rising edge
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;

	// result channel
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	// register write port
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [RATE_W-1:0] cfg_data = '0;

	// transactions waiting to be offered, and results still owed by the block
	item_t pending_items[$];
	result_t expected_results[$];
	result_t want_result;
	int queued_items = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int gap_left = 0;
	int stall_left = 0;
	// no idling on either side while set
	bit calm = 1'b0;

	// shadow of the configuration registers
	logic [RATE_W-1:0] rate_reg = RATE_RESET;
	logic enable_reg = 1'b0;

	// shadow of the tone state
	logic [PHASE_BITS-1:0] tone_phase = '0;
	logic [PHASE_BITS-1:0] tone_inc = '0;
	logic [31:0] tone_len = '0;
	logic [31:0] tone_pos = '0;
	logic [31:0] fade_len = '0;
	logic [31:0] tone_peak = '0;
	logic tone_on = 1'b0;

	square_tone_generator_with_fade_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// works out the answer to one transaction and advances the shadow tone state
	function automatic result_t next_tone_result(input item_t it);
		result_t r;
		logic [63:0] span;
		logic [63:0] fade;
		logic [63:0] shifted;
		logic [63:0] level;
		logic [31:0] mag;
		logic [31:0] remaining;
		logic positive;
		r = '{status: ST_OK, sample: '0, last: 1'b0};
		if (it.mode == MODE_START) begin
			// argument check; a rejected start leaves any running tone alone
			if (!enable_reg || rate_reg == '0 || it.freq_hz == '0 ||
					it.dur_ms == '0 || it.amplitude == '0 || it.amplitude > PEAK_MAX) begin
				r.status = ST_BAD_ARG;
				return r;
			end
			span = 64'(rate_reg) * 64'(it.dur_ms) / 64'd1000;
			if (span > 64'(COUNT_MAX))
				span = 64'(COUNT_MAX);
			fade = 64'(rate_reg) / 64'd200;
			if (fade > 64'(FADE_MAX))
				fade = 64'(FADE_MAX);
			tone_len = 32'(span);
			fade_len = 32'(fade);
			tone_peak = 32'(it.amplitude);
			tone_inc = PHASE_BITS'((64'(it.freq_hz) << PHASE_BITS) / 64'(rate_reg));
			tone_phase = '0;
			tone_pos = '0;
			// a zero sample count is accepted but plays nothing
			tone_on = (span != 64'd0);
			return r;
		end
		if (!tone_on) begin
			r.status = ST_IDLE;
			return r;
		end
		positive = tone_phase[PHASE_BITS-1];
		mag = tone_peak;
		// linear ramps in and out, each quotient truncated
		if (fade_len != 0 && tone_pos < fade_len)
			mag = mag * tone_pos / fade_len;
		remaining = tone_len - tone_pos;
		if (fade_len != 0 && remaining < fade_len)
			mag = mag * remaining / fade_len;
		shifted = 64'(mag) << SAMPLE_SHIFT;
		level = positive ? shifted : 64'd0 - shifted;
		tone_phase = tone_phase + tone_inc;
		tone_pos = tone_pos + 1;
		r.sample = level[SAMPLE_W-1:0];
		if (tone_pos >= tone_len) begin
			r.last = 1'b1;
			tone_on = 1'b0;
		end
		return r;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// driver: offers queued transactions, holds the payload while stalled
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				expected_results.push_back(next_tone_result(item));
				gap_left = idle_len();
			end
			if (!(item_valid && item_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: takes results, checks them against the oldest expectation
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d sample %0d last %0d",
							result.status, result.sample, result.last);
				end else begin
					want_result = expected_results.pop_front();
					if (result.status !== want_result.status ||
							result.sample !== want_result.sample ||
							result.last !== want_result.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("mismatch: expected status %0d sample %0d last %0d, ",
								want_result.status, want_result.sample, want_result.last);
							$display("got status %0d sample %0d last %0d",
								result.status, result.sample, result.last);
						end
					end
				end
			end
			// back-pressure, started at random points of the block's work
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				if (!calm && $urandom_range(0, 15) == 0)
					stall_left = idle_len();
			end
		end
	end

	// watchdog on the whole run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic add_item(input logic mode, input logic [FIELD_W-1:0] freq,
			input logic [FIELD_W-1:0] dur, input logic [FIELD_W-1:0] amp);
		pending_items.push_back('{mode: mode, freq_hz: freq, dur_ms: dur,
			amplitude: amp});
		queued_items++;
	endtask

	// ticks carry random payload, which the block ignores
	task automatic add_ticks(input int n);
		repeat (n)
			add_item(MODE_TICK, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
	endtask

	// waits until no transaction is queued, offered or owed
	task automatic settle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_RATE)
			rate_reg = val;
		else
			enable_reg = val[0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// a start sized to a modest sample count followed by ticks, mostly through its end
	task automatic add_tone();
		int span;
		int dur;
		int freq;
		int amp;
		int ticks;
		longint est;
		span = $urandom_range(1, 60);
		if (rate_reg == '0)
			dur = $urandom_range(1, 65535);
		else
			dur = (span * 1000 + int'(rate_reg) - 1) / int'(rate_reg);
		if ($urandom_range(0, 15) == 0)
			dur = $urandom_range(1, 65535);
		if (dur < 1)
			dur = 1;
		if (dur > 65535)
			dur = 65535;
		freq = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 65535);
		case ($urandom_range(0, 5))
			0: amp = 1;
			1: amp = 32767;
			default: amp = $urandom_range(1, 32767);
		endcase
		// broken start now and then
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: freq = 0;
				1: dur = 0;
				2: amp = 0;
				default: amp = $urandom_range(32768, 65535);
			endcase
		end
		est = longint'(rate_reg) * dur / 1000;
		if (est > 80)
			est = 80;
		// sometimes cut short so the next start lands mid-tone
		if ($urandom_range(0, 7) == 0)
			ticks = $urandom_range(0, int'(est));
		else
			ticks = int'(est) + $urandom_range(0, 2);
		add_item(MODE_START, FIELD_W'(freq), FIELD_W'(dur), FIELD_W'(amp));
		add_ticks(ticks);
	endtask

	initial begin
		int next_rate;
		int target;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration: output path off, so a start is refused
		add_item(MODE_START, 16'd440, 16'd10, 16'd1000);
		add_ticks(1);
		settle();

		write_reg(REG_ENABLE, RATE_W'(1));
		write_reg(REG_RATE, RATE_W'(1000));
		// each bad item field on its own
		add_item(MODE_START, 16'd0, 16'd10, 16'd1000);
		add_item(MODE_START, 16'd440, 16'd0, 16'd1000);
		add_item(MODE_START, 16'd440, 16'd10, 16'd0);
		add_item(MODE_START, 16'd440, 16'd10, 16'd32768);
		// short tone where the two ramps overlap, then an idle tick
		add_item(MODE_START, 16'hFFFF, 16'd4, 16'd32767);
		add_ticks(5);
		// long tone replaced by a new start while playing
		add_item(MODE_START, 16'd1, 16'hFFFF, 16'd1);
		add_ticks(2);
		add_item(MODE_START, 16'd300, 16'd3, 16'd100);
		add_ticks(3);
		add_item(MODE_START, 16'd500, 16'd20, 16'd20000);
		add_ticks(1);
		settle();

		// path switched off mid-tone: ticks go on, starts are refused
		write_reg(REG_ENABLE, RATE_W'(0));
		add_ticks(1);
		add_item(MODE_START, 16'd500, 16'd20, 16'd20000);
		add_ticks(1);
		settle();

		// lowest rate: empty tone, then a tone with no ramps
		write_reg(REG_ENABLE, RATE_W'(1));
		write_reg(REG_RATE, RATE_W'(1));
		add_item(MODE_START, 16'd1, 16'd999, 16'd5);
		add_ticks(1);
		add_item(MODE_START, 16'd7, 16'hFFFF, 16'd5);
		add_ticks(2);
		settle();

		// random phases, each under its own configuration
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: next_rate = 1;
				1: next_rate = 262143;
				2: next_rate = 192000;
				5: next_rate = 0;
				default: begin
					case ($urandom_range(0, 3))
						0: next_rate = $urandom_range(200, 4000);
						1: next_rate = 16000;
						2: next_rate = $urandom_range(1, 262143);
						default: next_rate = $urandom_range(500, 2000);
					endcase
				end
			endcase
			write_reg(REG_RATE, RATE_W'(next_rate));
			write_reg(REG_ENABLE, RATE_W'((ph % 4 == 3) ? 0 : 1));
			calm = (ph % 4 == 1);
			// saturated sample count at the top rate
			if (ph == 1) begin
				add_item(MODE_START, 16'd1000, 16'hFFFF, 16'd32767);
				add_ticks(3);
			end
			target = queued_items + PHASE_ITEMS;
			while (queued_items < target) begin
				if ($urandom_range(0, 9) < 8)
					add_tone();
				else
					repeat ($urandom_range(1, 4))
						add_item(1'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
							FIELD_W'($urandom));
			end
			settle();
		end

		calm = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
